// ===== design/ptrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrr_pkg: shared types and constants of the round-robin task scheduler
// Slot table geometry, command and status codes, slot states and the
// control group passed from the sequencer to the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrr_pkg;

	localparam int SLOTS        = 16;
	localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_FIELD_W = 4;
	localparam int ID_W         = 16;
	localparam int WORD_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;

	localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE       = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_CURRENT = 2'd2;

	localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
	localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_UNUSED   = 2'd0,
		ST_READY    = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_FINISHED = 2'd3
	} slot_state_t;

	typedef struct packed {
		logic [ID_W-1:0]   pid;
		logic [WORD_W-1:0] entry;
		logic [WORD_W-1:0] arg;
	} slot_data_t;

	typedef struct packed {
		logic        state_we;
		slot_state_t state_wd;
		logic        data_we;
	} tbl_req_t;

endpackage

`default_nettype wire

// ===== design/ptrr_table.sv =====
// ----------------------------------------------------------------------------
// ptrr_table: slot table of the scheduler
// Per-slot state in flops cleared by reset, plus a memory holding the id,
// entry word and argument word of each slot. One index serves all access.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrr_table
	import ptrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] idx,
	input  wire tbl_req_t          req,
	input  wire slot_data_t        wdata,
	output slot_state_t            state_rd,
	output slot_data_t             rdata
);

	slot_state_t state_q [SLOTS];
	slot_data_t  mem [SLOTS];
	slot_data_t  rdata_q;

	// hold slot states; only reset clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i] <= ST_UNUSED;
			end
		end else if (req.state_we) begin
			state_q[idx] <= req.state_wd;
		end
	end

	// slot words: single port, registered read
	always_ff @(posedge clk) begin
		if (req.data_we) begin
			mem[idx] <= wdata;
		end
		rdata_q <= mem[idx];
	end

	assign state_rd = state_q[idx];
	assign rdata    = rdata_q;

endmodule

`default_nettype wire

// ===== design/process_table_round_robin_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// process_table_round_robin_scheduler_core: round-robin task scheduler
// Create and dispatch search with the shared compare unit, one slot per cycle;
// create answers on the first unused slot, dispatch claims the first ready
// slot and goes on through READ and EMIT; a search that finds nothing ends once
// all SLOTS slots are visited. Yield, finish and query go through READ and EMIT;
// with no current task, or for an unknown command, the reply comes from IDLE.
// Throughput: one command at a time; busy stays high until the result.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (arst_n low) clears all slot states and the current task, and sets the next id to ID_FIRST.
// ----------------------------------------------------------------------------
`default_nettype none

module process_table_round_robin_scheduler_core
	import ptrr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [CMD_W-1:0]        cmd,
	input  wire logic [WORD_W-1:0]       entry_addr,
	input  wire logic [WORD_W-1:0]       entry_arg,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic                         has_pid,
	output logic [ID_W-1:0]              pid,
	output logic [SLOT_FIELD_W-1:0]      slot,
	output logic [WORD_W-1:0]            out_entry,
	output logic [WORD_W-1:0]            out_arg
);

	// IDLE: wait for a command. SCAN: visit one slot per cycle.
	// READ: table memory read in flight. EMIT: build the result.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EMIT
	} fsm_t;

	fsm_t              fsm_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [WORD_W-1:0] addr_q;
	logic [WORD_W-1:0] arg_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              cur_valid_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [ID_W-1:0]   next_id_q;

	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  has_pid_q;
	logic [ID_W-1:0]       pid_q;
	logic [SLOT_FIELD_W-1:0] slot_q;
	logic [WORD_W-1:0]     entry_q;
	logic [WORD_W-1:0]     arg_out_q;

	slot_state_t state_rd;
	slot_data_t  rdata;
	slot_data_t  wdata;
	tbl_req_t    req;
	logic        is_create;
	logic        hit;
	logic [SLOT_W-1:0] idx_inc;
	logic [SLOT_W-1:0] cur_inc;

	// slot table: states in flops, words in a single-port memory
	ptrr_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (idx_q),
		.req      (req),
		.wdata    (wdata),
		.state_rd (state_rd),
		.rdata    (rdata)
	);

	// the shared compare unit: one slot state against the wanted state
	assign is_create = (cmd_q == CMD_CREATE);
	assign hit       = is_create ? (state_rd == ST_UNUSED) : (state_rd == ST_READY);

	// advance round-robin, wrapping at the table end
	assign idx_inc = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign cur_inc = (cur_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_slot_q + 1'b1;

	assign wdata.pid   = next_id_q;
	assign wdata.entry = addr_q;
	assign wdata.arg   = arg_q;

	// table writes: claim on a scan hit, state update for yield and finish
	always_comb begin
		req.state_we = 1'b0;
		req.state_wd = ST_UNUSED;
		req.data_we  = 1'b0;
		case (fsm_q)
			S_SCAN: begin
				if (hit) begin
					req.state_we = 1'b1;
					req.state_wd = is_create ? ST_READY : ST_RUNNING;
					req.data_we  = is_create;
				end
			end
			S_READ: begin
				if (cmd_q == CMD_YIELD && state_rd == ST_RUNNING) begin
					req.state_we = 1'b1;
					req.state_wd = ST_READY;
				end else if (cmd_q == CMD_FINISH) begin
					req.state_we = 1'b1;
					req.state_wd = ST_FINISHED;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			cmd_q       <= CMD_CREATE;
			addr_q      <= '0;
			arg_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			next_id_q   <= ID_FIRST;
			done_q      <= 1'b0;
			status_q    <= STATUS_OK;
			has_pid_q   <= 1'b0;
			pid_q       <= '0;
			slot_q      <= '0;
			entry_q     <= '0;
			arg_out_q   <= '0;
		end else begin
			// strobe lasts one cycle; result fields are cleared when a command is taken
			done_q    <= 1'b0;
			case (fsm_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						addr_q    <= entry_addr;
						arg_q     <= entry_arg;
						cnt_q     <= '0;
						status_q  <= STATUS_OK;
						has_pid_q <= 1'b0;
						pid_q     <= '0;
						slot_q    <= '0;
						entry_q   <= '0;
						arg_out_q <= '0;
						case (cmd)
							CMD_CREATE: begin
								idx_q <= '0;
								fsm_q <= S_SCAN;
							end
							CMD_DISPATCH: begin
								// start after the current slot, or at slot zero
								idx_q <= cur_valid_q ? cur_inc : '0;
								fsm_q <= S_SCAN;
							end
							CMD_YIELD, CMD_FINISH, CMD_QUERY: begin
								if (cur_valid_q) begin
									idx_q <= cur_slot_q;
									fsm_q <= S_READ;
								end else begin
									status_q <= STATUS_NO_CURRENT;
									done_q   <= 1'b1;
								end
							end
							default: begin
								// unknown command: drop it, report ok
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (is_create) begin
							status_q  <= STATUS_OK;
							has_pid_q <= 1'b1;
							pid_q     <= next_id_q;
							slot_q    <= SLOT_FIELD_W'(idx_q);
							done_q    <= 1'b1;
							next_id_q <= (next_id_q == ID_LAST) ? ID_FIRST
							                                    : next_id_q + 1'b1;
							fsm_q     <= S_IDLE;
						end else begin
							cur_valid_q <= 1'b1;
							cur_slot_q  <= idx_q;
							fsm_q       <= S_READ;
						end
					end else if (cnt_q == SLOT_W'(SLOTS - 1)) begin
						// whole table visited: full, or nothing ready
						status_q <= STATUS_NONE;
						done_q   <= 1'b1;
						fsm_q    <= S_IDLE;
					end else begin
						idx_q <= idx_inc;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_READ: begin
					fsm_q <= S_EMIT;
				end
				S_EMIT: begin
					status_q  <= STATUS_OK;
					has_pid_q <= 1'b1;
					pid_q     <= rdata.pid;
					slot_q    <= SLOT_FIELD_W'(idx_q);
					if (cmd_q == CMD_DISPATCH) begin
						entry_q   <= rdata.entry;
						arg_out_q <= rdata.arg;
					end
					done_q <= 1'b1;
					fsm_q  <= S_IDLE;
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (fsm_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign has_pid   = has_pid_q;
	assign pid       = pid_q;
	assign slot      = slot_q;
	assign out_entry = entry_q;
	assign out_arg   = arg_out_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the round-robin task scheduler core
// Drives create, dispatch, yield, finish, query and reserved commands through
// the start/busy handshake, keeps its own model of the slot table and
// compares every result strobe field by field against the predicted reply.
// ----------------------------------------------------------------------------
module tb;
	import ptrr_pkg::*;

	// Command codes past query are reserved; the core answers them with zeros.
	localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

	localparam int RANDOM_CMDS = 750;
	localparam int MAX_GAP     = 18;
	// Longest command is dispatch over a full scan; add slack for the drain.
	localparam int DRAIN_WAIT  = 2 * SLOTS + 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic                    has_pid;
		logic [ID_W-1:0]         pid;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [WORD_W-1:0]       entry;
		logic [WORD_W-1:0]       arg;
	} sched_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [CMD_W-1:0]        cmd;
	logic [WORD_W-1:0]       entry_addr;
	logic [WORD_W-1:0]       entry_arg;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic                    has_pid;
	logic [ID_W-1:0]         pid;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [WORD_W-1:0]       out_entry;
	logic [WORD_W-1:0]       out_arg;

	// Shadow copy of the slot table and the scheduler registers.
	slot_state_t       tbl_state [SLOTS];
	logic [ID_W-1:0]   tbl_pid   [SLOTS];
	logic [WORD_W-1:0] tbl_entry [SLOTS];
	logic [WORD_W-1:0] tbl_arg   [SLOTS];
	logic              cur_valid;
	int                cur_slot;
	logic [ID_W-1:0]   id_next;

	sched_reply_t replies_due[$];
	sched_reply_t reply_exp;
	int           mismatch_count;
	int           cycle_count;
	bit           no_idle;

	process_table_round_robin_scheduler_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.entry_addr (entry_addr),
		.entry_arg  (entry_arg),
		.done       (done),
		.status     (status),
		.has_pid    (has_pid),
		.pid        (pid),
		.slot       (slot),
		.out_entry  (out_entry),
		.out_arg    (out_arg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow table and return the reply it earns.
	function automatic sched_reply_t schedule_cmd(logic [CMD_W-1:0] op,
			logic [WORD_W-1:0] ea, logic [WORD_W-1:0] eg);
		sched_reply_t r;
		int           i;
		int           k;
		int           first;
		bit           hit;
		r   = '0;
		hit = 1'b0;
		case (op)
			CMD_CREATE: begin
				// Claim the lowest unused slot; finished slots stay claimed.
				for (i = 0; i < SLOTS; i++) begin
					if (!hit && tbl_state[i] == ST_UNUSED) begin
						hit = 1'b1;
						k   = i;
					end
				end
				if (hit) begin
					tbl_state[k] = ST_READY;
					tbl_pid[k]   = id_next;
					tbl_entry[k] = ea;
					tbl_arg[k]   = eg;
					r.has_pid    = 1'b1;
					r.pid        = id_next;
					r.slot       = k[SLOT_FIELD_W-1:0];
					id_next      = (id_next == ID_LAST) ? ID_FIRST : id_next + 1'b1;
				end else begin
					r.status = STATUS_NONE;
				end
			end
			CMD_DISPATCH: begin
				// Search round-robin from the slot after the current one.
				first = cur_valid ? (cur_slot + 1) % SLOTS : 0;
				for (i = 0; i < SLOTS; i++) begin
					if (!hit && tbl_state[(first + i) % SLOTS] == ST_READY) begin
						hit = 1'b1;
						k   = (first + i) % SLOTS;
					end
				end
				if (hit) begin
					tbl_state[k] = ST_RUNNING;
					cur_slot     = k;
					cur_valid    = 1'b1;
					r.has_pid    = 1'b1;
					r.pid        = tbl_pid[k];
					r.slot       = k[SLOT_FIELD_W-1:0];
					r.entry      = tbl_entry[k];
					r.arg        = tbl_arg[k];
				end else begin
					r.status = STATUS_NONE;
				end
			end
			CMD_YIELD, CMD_FINISH, CMD_QUERY: begin
				if (!cur_valid) begin
					r.status = STATUS_NO_CURRENT;
				end else begin
					if (op == CMD_YIELD && tbl_state[cur_slot] == ST_RUNNING)
						tbl_state[cur_slot] = ST_READY;
					if (op == CMD_FINISH)
						tbl_state[cur_slot] = ST_FINISHED;
					r.has_pid = 1'b1;
					r.pid     = tbl_pid[cur_slot];
					r.slot    = cur_slot[SLOT_FIELD_W-1:0];
				end
			end
			default: begin
				// Reserved codes: no state change, all-zero reply.
			end
		endcase
		return r;
	endfunction

	// Present one command, hold it until the core takes it, log the reply due.
	task automatic send_cmd(logic [CMD_W-1:0] op, logic [WORD_W-1:0] ea,
			logic [WORD_W-1:0] eg);
		int gap;
		// Flip between idle-free bursts and randomly gapped traffic now and then.
		if ($urandom_range(0, 19) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd        = op;
		entry_addr = ea;
		entry_arg  = eg;
		start      = 1'b1;
		// A transfer happens at the first rising edge that sees busy low.
		do @(posedge clk); while (busy);
		replies_due.push_back(schedule_cmd(op, ea, eg));
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] exp_v,
			logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Every strobe is one transfer; match it against the oldest reply due.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with none expected: status %0h pid %0h slot %0h",
					$time, status, pid, slot);
				mismatch_count++;
			end else begin
				reply_exp = replies_due.pop_front();
				check_field("status", WORD_W'(reply_exp.status), WORD_W'(status));
				check_field("has_pid", WORD_W'(reply_exp.has_pid), WORD_W'(has_pid));
				check_field("pid", WORD_W'(reply_exp.pid), WORD_W'(pid));
				check_field("slot", WORD_W'(reply_exp.slot), WORD_W'(slot));
				check_field("out_entry", reply_exp.entry, out_entry);
				check_field("out_arg", reply_exp.arg, out_arg);
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("process_table_round_robin_scheduler_core: mismatch");
			$finish;
		end
	end

	// With nothing current: yield, finish and query report no task, and
	// dispatch on an empty table finds nothing ready.
	task automatic test_no_current();
		send_cmd(CMD_QUERY, $urandom, $urandom);
		send_cmd(CMD_YIELD, $urandom, $urandom);
		send_cmd(CMD_FINISH, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
	endtask

	// Create with extreme words, then dispatch from slot 0, dispatch over a
	// running current task, and run out of ready slots.
	task automatic test_create_dispatch();
		send_cmd(CMD_CREATE, '0, '1);
		send_cmd(CMD_CREATE, '1, '0);
		send_cmd(CMD_CREATE, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
	endtask

	// Yield a running task, yield one that is already ready, re-dispatch it,
	// finish it, poke it again after finish and query the current id.
	task automatic test_yield_finish();
		send_cmd(CMD_YIELD, $urandom, $urandom);
		send_cmd(CMD_YIELD, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
		send_cmd(CMD_FINISH, $urandom, $urandom);
		send_cmd(CMD_YIELD, $urandom, $urandom);
		send_cmd(CMD_QUERY, $urandom, $urandom);
		send_cmd(CMD_DISPATCH, $urandom, $urandom);
	endtask

	task automatic test_reserved_cmds();
		send_cmd(CMD_RSVD_LO, $urandom, $urandom);
		send_cmd(CMD_RSVD_MID, $urandom, $urandom);
		send_cmd(CMD_RSVD_HI, $urandom, $urandom);
	endtask

	// Mixed traffic. Keep finish rare so ready tasks last through the run and
	// dispatch keeps rotating past slot 15; creates soon hit a full table.
	task automatic test_random_mix();
		int               n;
		int               pick;
		logic [CMD_W-1:0] op;
		n = 0;
		while (n < RANDOM_CMDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 12)
				op = CMD_CREATE;
			else if (pick < 50)
				op = CMD_DISPATCH;
			else if (pick < 77)
				op = CMD_YIELD;
			else if (pick < 79)
				op = CMD_FINISH;
			else if (pick < 96)
				op = CMD_QUERY;
			else
				op = CMD_RSVD_LO + CMD_W'($urandom_range(0, 2));
			send_cmd(op, $urandom, $urandom);
			if (op <= CMD_QUERY)
				n++;
		end
	endtask

	initial begin
		// Hold every input at a known value through reset.
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = CMD_QUERY;
		entry_addr     = '0;
		entry_arg      = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		no_idle        = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = ST_UNUSED;
			tbl_pid[i]   = '0;
			tbl_entry[i] = '0;
			tbl_arg[i]   = '0;
		end
		cur_valid = 1'b0;
		cur_slot  = 0;
		id_next   = ID_FIRST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_current();
		test_create_dispatch();
		test_yield_finish();
		test_reserved_cmds();
		test_random_mix();

		// Drop start after the last transfer and drain outstanding replies.
		@(negedge clk);
		start = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("process_table_round_robin_scheduler_core: match");
		else
			$display("process_table_round_robin_scheduler_core: mismatch");
		$finish;
	end

endmodule
